[rtl/lnasm_pkg.sv]
// Shared types and constants for the line assembler.
// No dependencies; used by lnasm_ctrl, lnasm_dp and the top level.
package lnasm_pkg;

	localparam int LINE_CAPACITY_DEF = 64;
	localparam int BYTE_W            = 8;
	localparam int OVF_W             = 16;

	localparam logic [BYTE_W-1:0] CR_BYTE        = 8'h0D;
	localparam logic [BYTE_W-1:0] LINE_END_RESET = 8'h0A;

	// Controller to datapath
	typedef struct packed {
		logic accept;   // input side open
		logic rd_en;    // read store at the readout pointer
		logic load;     // move read data into the output register, advance pointer
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic line_done; // accepted byte closes a non-empty line
		logic out_free;  // output register empty or being taken this cycle
		logic rd_last;   // readout pointer sits on the final byte of the line
	} sts_t;

endpackage

[rtl/lnasm_ctrl.sv]
// Readout sequencer for the line assembler.
// Depends on lnasm_pkg for the command and status structs.
module lnasm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  lnasm_pkg::sts_t   sts,
	output lnasm_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sts.line_done) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					// hold until the output register can take the next byte
					if (sts.out_free) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= sts.rd_last ? ST_IDLE : ST_FETCH;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.accept = (state_q == ST_IDLE);
		cmd.rd_en  = (state_q == ST_FETCH) && sts.out_free;
		cmd.load   = (state_q == ST_LOAD);
	end

endmodule

[rtl/lnasm_dp.sv]
// Datapath of the line assembler: line store, fill count, discard flag,
// overflow counter, readout pointer and output register. Depends on lnasm_pkg.
module lnasm_dp #(
	parameter int LINE_CAPACITY = lnasm_pkg::LINE_CAPACITY_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	input  logic [lnasm_pkg::BYTE_W-1:0]              cfg_data,
	input  logic                                      s_tvalid,
	input  logic [lnasm_pkg::BYTE_W-1:0]              s_tdata,
	input  logic                                      m_tready,
	output logic                                      m_tvalid,
	output logic [lnasm_pkg::OVF_W+lnasm_pkg::BYTE_W-1:0] m_tdata,
	output logic                                      m_tlast,
	input  lnasm_pkg::cmd_t                           cmd,
	output lnasm_pkg::sts_t                           sts
);

	localparam int DEPTH  = LINE_CAPACITY - 1;
	localparam int FILL_W = $clog2(LINE_CAPACITY);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

	logic [lnasm_pkg::BYTE_W-1:0] mem [DEPTH];

	logic [lnasm_pkg::BYTE_W-1:0] line_end_q;
	logic [FILL_W-1:0]            fill_q;
	logic [FILL_W-1:0]            fill_dec;
	logic                         discard_q;
	logic [lnasm_pkg::OVF_W-1:0]  ovf_q;
	logic [IDX_W-1:0]             rd_ptr_q;
	logic [IDX_W-1:0]             last_idx_q;
	logic [lnasm_pkg::BYTE_W-1:0] rd_data_q;
	logic                         out_valid_q;
	logic [lnasm_pkg::BYTE_W-1:0] out_byte_q;
	logic                         out_last_q;
	logic [lnasm_pkg::OVF_W-1:0]  out_ovf_q;

	logic in_fire;
	logic is_cr;
	logic is_end;
	logic fill_empty;
	logic fill_full;
	logic wr_en;

	assign in_fire    = s_tvalid && cmd.accept;
	assign is_cr      = (s_tdata == lnasm_pkg::CR_BYTE);
	assign is_end     = (s_tdata == line_end_q);
	assign fill_empty = (fill_q == '0);
	assign fill_full  = (fill_q == FILL_MAX);
	assign fill_dec   = fill_q - 1'b1;
	assign wr_en      = in_fire && !is_cr && !is_end && !discard_q && !fill_full;

	always_comb begin
		sts.line_done = in_fire && !is_cr && is_end && !discard_q && !fill_empty;
		sts.out_free  = !out_valid_q || m_tready;
		sts.rd_last   = (rd_ptr_q == last_idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_end_q <= lnasm_pkg::LINE_END_RESET;
		end else if (cfg_valid) begin
			line_end_q <= cfg_data;
		end
	end

	// Gather, close and discard lines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			discard_q <= 1'b0;
			ovf_q     <= '0;
		end else if (in_fire && !is_cr) begin
			priority if (is_end) begin
				discard_q <= 1'b0;
				fill_q    <= '0;
			end else if (discard_q) begin
				discard_q <= 1'b1;
			end else if (fill_full) begin
				// over-long line: count once, drop until the next line end
				if (ovf_q != '1) begin
					ovf_q <= ovf_q + 1'b1;
				end
				discard_q <= 1'b1;
				fill_q    <= '0;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[IDX_W-1:0]] <= s_tdata;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			last_idx_q <= '0;
		end else if (sts.line_done) begin
			rd_ptr_q   <= '0;
			last_idx_q <= fill_dec[IDX_W-1:0];
		end else if (cmd.load) begin
			rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q <= rd_data_q;
			out_last_q <= sts.rd_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ovf_q, out_byte_q};
	assign m_tlast  = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill count beyond store depth");

	a_discard_empty: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> fill_empty)
		else $error("store not empty while discarding");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !out_valid_q)
		else $error("output register overwritten");

	a_ovf_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_q != $past(ovf_q)) |-> (ovf_q == $past(ovf_q) + 1'b1))
		else $error("overflow count moved by other than one");

	a_no_write_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en || cmd.load) |-> !wr_en)
		else $error("store written during readout");

endmodule

[rtl/line_assembler_with_overflow_discard.sv]
// Top level of the line assembler: joins lnasm_ctrl and lnasm_dp.
// Depends on lnasm_pkg.
//
//  channel  | direction | signals                      | payload
//  ---------+-----------+------------------------------+-------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata    | rx_byte
//  m_       | out       | m_tvalid m_tready m_tdata    | line_byte, overflow_total, tlast
//  cfg_     | in        | cfg_valid cfg_ready cfg_data | line_end_char
//
// The input stays open except while a line is read out. Readout of each byte is a store
// read, then an output register load, and waits while the output stalls; the last byte
// leaves in the output register while input reopens.
// Reset (arst_n low) empties the line, leaves discard mode, zeroes the overflow count and
// sets the line end to 0x0A. Store contents are not cleared and need no clearing pass.
module line_assembler_with_overflow_discard #(
	parameter int LINE_CAPACITY = lnasm_pkg::LINE_CAPACITY_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [lnasm_pkg::BYTE_W-1:0]                  cfg_data,  // line_end_char
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	input  logic [lnasm_pkg::BYTE_W-1:0]                  s_tdata,   // [7:0] rx_byte
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// [7:0] line_byte, [23:8] overflow_total
	output logic [lnasm_pkg::OVF_W+lnasm_pkg::BYTE_W-1:0] m_tdata,
	output logic                                          m_tlast    // line_last
);

	lnasm_pkg::cmd_t cmd;
	lnasm_pkg::sts_t sts;

	assign cfg_ready = 1'b1;
	assign s_tready  = cmd.accept;

	lnasm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	lnasm_dp #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[tb/tb_line_assembler_with_overflow_discard.sv]
// Self-checking testbench for line_assembler_with_overflow_discard.
// Streams received bytes in, predicts every emitted line byte and compares field by field.
// Depends on lnasm_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module tb_line_assembler_with_overflow_discard;

	localparam int BYTE_W         = lnasm_pkg::BYTE_W;
	localparam int OVF_W          = lnasm_pkg::OVF_W;
	localparam int LINE_BYTES_MAX = lnasm_pkg::LINE_CAPACITY_DEF - 1;
	localparam int RANDOM_ITEMS   = 45;

	typedef struct packed {
		logic [OVF_W-1:0]  total;
		logic              last;
		logic [BYTE_W-1:0] data;
	} line_beat_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [BYTE_W-1:0]       cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [BYTE_W-1:0]       s_tdata;
	logic                    m_tvalid;
	logic                    m_tready = 1'b1;
	logic [OVF_W+BYTE_W-1:0] m_tdata;
	logic                    m_tlast;

	// Predictor state
	logic [BYTE_W-1:0] gather_buf [0:LINE_BYTES_MAX-1];
	int unsigned       gather_len;
	bit                dropping;
	logic [OVF_W-1:0]  overlong_count;
	logic [BYTE_W-1:0] eol_char;

	line_beat_t line_beats_due [$];

	bit          no_gaps = 1'b0;
	int unsigned rx_hold = 0;
	int unsigned fail_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned lines_seen = 0;
	int unsigned eol_writes = 0;

	line_assembler_with_overflow_discard dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic clear_predictor();
		gather_len     = 0;
		dropping       = 1'b0;
		overlong_count = '0;
		eol_char       = lnasm_pkg::LINE_END_RESET;
	endtask

	// Advance the predicted framer by one received byte; queue any line it completes.
	task automatic frame_byte(input logic [BYTE_W-1:0] b);
		line_beat_t beat;
		if (b == lnasm_pkg::CR_BYTE)
			return;
		if (b == eol_char) begin
			if (dropping) begin
				dropping   = 1'b0;
				gather_len = 0;
				return;
			end
			for (int i = 0; i < gather_len; i++) begin
				beat.data  = gather_buf[i];
				beat.last  = (i + 1 == gather_len);
				beat.total = overlong_count;
				line_beats_due.push_back(beat);
			end
			gather_len = 0;
			return;
		end
		if (dropping)
			return;
		if (gather_len < LINE_BYTES_MAX) begin
			gather_buf[gather_len] = b;
			gather_len++;
		end else begin
			if (overlong_count != '1)
				overlong_count++;
			dropping   = 1'b1;
			gather_len = 0;
		end
	endtask

	// Send one byte after a random gap; valid stays high for a back-to-back follower.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		frame_byte(b);
		bytes_sent++;
	endtask

	// Random line body of the given length, avoiding the line end, then the line end.
	task automatic send_line(input int len);
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < len; i++) begin
			do b = BYTE_W'($urandom_range(0, 255)); while (b == eol_char);
			send_byte(b);
		end
		send_byte(eol_char);
	endtask

	// Hold the input until every predicted byte has left, then let the readout finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (line_beats_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_line_end(input logic [BYTE_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		eol_char = v;
		eol_writes++;
	endtask

	// Result side: check each transaction, then draw the stall before the next one.
	always @(posedge clk) begin
		line_beat_t want;
		if (m_tvalid && m_tready) begin
			if (line_beats_due.size() == 0) begin
				$error("unexpected line byte %02h (last %0b, total %0d)",
					m_tdata[BYTE_W-1:0], m_tlast, m_tdata[OVF_W+BYTE_W-1:BYTE_W]);
				fail_count++;
			end else begin
				want = line_beats_due.pop_front();
				if (m_tdata[BYTE_W-1:0] !== want.data) begin
					$error("line_byte: expected %02h, got %02h", want.data,
						m_tdata[BYTE_W-1:0]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("line_last: expected %0b, got %0b", want.last, m_tlast);
					fail_count++;
				end
				if (m_tdata[OVF_W+BYTE_W-1:BYTE_W] !== want.total) begin
					$error("overflow_total: expected %0d, got %0d", want.total,
						m_tdata[OVF_W+BYTE_W-1:BYTE_W]);
					fail_count++;
				end
			end
			if (m_tlast)
				lines_seen++;
			rx_hold = no_gaps ? 0 : $urandom_range(0, 16);
		end else if (rx_hold != 0) begin
			rx_hold--;
		end
		m_tready <= (rx_hold == 0);
	end

	// Field extremes, carriage returns inside a line, blank lines.
	task automatic test_short_lines();
		send_byte(8'h00);
		send_byte(eol_char);
		send_byte(8'hFF);
		send_byte(8'h41);
		send_byte(lnasm_pkg::CR_BYTE);
		send_byte(8'h42);
		send_byte(eol_char);
		send_byte(eol_char);
		send_byte(lnasm_pkg::CR_BYTE);
		send_byte(lnasm_pkg::CR_BYTE);
		send_byte(eol_char);
		send_byte(8'h7E);
		send_byte(eol_char);
		settle();
	endtask

	// A carriage return as line end never closes a line; 0x0A becomes data.
	task automatic test_cr_line_end();
		set_line_end(lnasm_pkg::CR_BYTE);
		send_byte(8'h31);
		send_byte(lnasm_pkg::CR_BYTE);
		send_byte(8'h0A);
		send_byte(8'h32);
		set_line_end(lnasm_pkg::LINE_END_RESET);
		send_byte(lnasm_pkg::LINE_END_RESET);
		settle();
	endtask

	task automatic test_line_end_extremes();
		set_line_end(8'h00);
		send_byte(8'h0A);
		send_byte(8'hFF);
		send_byte(8'h00);
		set_line_end(8'hFF);
		send_byte(8'h00);
		send_byte(8'h0A);
		send_byte(8'hFF);
		set_line_end(lnasm_pkg::LINE_END_RESET);
	endtask

	// Longest line that still fits, read out against a stalling receiver.
	task automatic test_full_line();
		send_line(LINE_BYTES_MAX);
		settle();
	endtask

	// Over-long lines: drop to the next line end, then count in later lines.
	task automatic test_overflow();
		for (int i = 0; i <= LINE_BYTES_MAX; i++)
			send_byte(8'h60 + i[4:0]);
		send_byte(8'h11);
		send_byte(lnasm_pkg::CR_BYTE);
		send_byte(8'h22);
		send_byte(eol_char);
		send_byte(eol_char);
		send_line(1);
		send_line(LINE_BYTES_MAX + 1);
		send_line(2);
		settle();
	endtask

	task automatic test_random_traffic();
		int unsigned      start;
		int unsigned      pick;
		int               len;
		bit               pressed;
		logic [BYTE_W-1:0] next_eol;
		start   = bytes_sent;
		pressed = 1'b0;
		while (bytes_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 11) == 0) begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: next_eol = lnasm_pkg::LINE_END_RESET;
					1: next_eol = 8'h00;
					2: next_eol = 8'hFF;
					default: next_eol = BYTE_W'($urandom_range(0, 255));
				endcase
				set_line_end(next_eol);
			end
			if (!pressed && bytes_sent - start >= RANDOM_ITEMS / 2) begin
				settle();
				pressed = 1'b1;
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			pick    = $urandom_range(0, 99);
			if (pick < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 85)
					len = $urandom_range(0, 20);
				else if (pick < 95)
					len = $urandom_range(21, LINE_BYTES_MAX);
				else
					len = $urandom_range(LINE_BYTES_MAX, LINE_BYTES_MAX + 7);
				if ($urandom_range(0, 7) == 0)
					send_byte(lnasm_pkg::CR_BYTE);
				send_line(len);
			end else begin
				// noise: raw bytes of any value, line end and carriage return included
				repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
		no_gaps = 1'b0;
		send_byte(eol_char);
		settle();
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		clear_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_lines();
		test_cr_line_end();
		test_line_end_extremes();
		test_full_line();
		test_overflow();
		test_random_traffic();

		$display("Run covered %0d received bytes, %0d lines read out, %0d over-long lines,",
			bytes_sent, lines_seen, overlong_count);
		$display("and %0d line-end settings with carriage returns, blank lines and stalls.",
			eol_writes);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
